[hw/rtl/dst_pkg.sv]
// Package with the types, constants and register codes shared by the tokenizer modules.
`timescale 1ns / 1ps

package dst_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int LEN_W       = 11;
    localparam int CONSUMED_W  = 16;
    localparam int MASK_W      = 256;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [COUNT_W-1:0]    MAX_TOKENS    = 9'd256;
    localparam logic [LEN_W-1:0]      MAX_TOKEN_LEN = 11'd2047;
    localparam logic [CONSUMED_W-1:0] CONSUMED_MAX  = 16'hFFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_0       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_1       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_2       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_3       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_EMPTY   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TOKEN_LEN = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TOKENS    = 3'd6;

    localparam logic [1:0] PH_BETWEEN    = 2'd0;
    localparam logic [1:0] PH_SKIPPING   = 2'd1;
    localparam logic [1:0] PH_COLLECTING = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              is_zero;
        logic              is_delim;
    } dst_item_t;

    typedef struct packed {
        logic              allow_empty;
        logic [LEN_W-1:0]  max_token_len;
        logic [COUNT_W-1:0] max_tokens;
    } dst_cfg_t;

    typedef struct packed {
        logic [CONSUMED_W-1:0] consumed_len;
        logic [COUNT_W-1:0]    token_total;
        logic                  string_done;
        logic                  token_closed;
        logic [BYTE_W-1:0]     token_slot;
        logic                  byte_kept;
        logic [BYTE_W-1:0]     token_byte;
    } dst_result_t;

endpackage

[hw/rtl/dst_front.sv]
// Front end: accepts input words and classifies each byte as terminator or delimiter.
`timescale 1ns / 1ps

module dst_front
    import dst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [MASK_W-1:0] delim_mask,
    output logic              push_valid,
    input  logic              queue_full,
    output dst_item_t         push_item
);

    logic      item_valid_reg;
    logic      item_valid_next;
    dst_item_t item_reg;
    logic      push_done;
    logic      load;

    assign push_done  = item_valid_reg && !queue_full;
    assign in_ready   = !item_valid_reg || push_done;
    assign load       = in_valid && in_ready;
    assign push_valid = push_done;
    assign push_item  = item_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (load)
        begin
            item_valid_next = 1'b1;
        end
        else if (push_done)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.byte_value <= in_byte;
            item_reg.is_zero    <= (in_byte == '0);
            item_reg.is_delim   <= delim_mask[in_byte];
        end
    end

endmodule

[hw/rtl/dst_queue.sv]
// Short queue of classified bytes between the front end and the back end.
`timescale 1ns / 1ps

module dst_queue
    import dst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  dst_item_t push_item,
    output logic      full,
    output logic      pop_valid,
    input  logic      pop_ready,
    output dst_item_t pop_item
);

    dst_item_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_valid && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/dst_back.sv]
// Back end: token state update for each classified byte, with a registered result.
`timescale 1ns / 1ps

module dst_back
    import dst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dst_cfg_t    cfg,
    input  logic        item_valid,
    output logic        item_ready,
    input  dst_item_t   item,
    output logic        out_valid,
    input  logic        out_ready,
    output dst_result_t out_result
);

    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    logic [COUNT_W-1:0]    token_count_reg;
    logic [COUNT_W-1:0]    token_count_next;
    logic [LEN_W-1:0]      kept_len_reg;
    logic [LEN_W-1:0]      kept_len_next;
    logic [CONSUMED_W-1:0] consumed_reg;
    logic [CONSUMED_W-1:0] consumed_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    dst_result_t           result_reg;
    dst_result_t           result_next;
    logic [COUNT_W-1:0]    token_limit;
    logic                  fire;

    assign item_ready = !out_valid_reg || out_ready;
    assign fire       = item_valid && item_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign token_limit = (cfg.max_tokens > MAX_TOKENS) ? MAX_TOKENS : cfg.max_tokens;

    always_comb
    begin
        phase_next       = phase_reg;
        token_count_next = token_count_reg;
        kept_len_next    = kept_len_reg;
        consumed_next    = consumed_reg;

        result_next.token_byte   = item.byte_value;
        result_next.byte_kept    = 1'b0;
        result_next.token_slot   = '0;
        result_next.token_closed = 1'b0;
        result_next.string_done  = 1'b0;
        result_next.token_total  = token_count_reg;
        result_next.consumed_len = consumed_reg;

        if (item.is_zero)
        begin
            result_next.string_done = 1'b1;
            if (phase_reg != PH_BETWEEN)
            begin
                result_next.token_slot   = token_count_reg[BYTE_W-1:0];
                result_next.token_closed = 1'b1;
                result_next.token_total  = token_count_reg + 1'b1;
            end
            phase_next       = PH_BETWEEN;
            token_count_next = '0;
            kept_len_next    = '0;
            consumed_next    = '0;
        end
        else if (!(phase_reg == PH_BETWEEN && token_count_reg >= token_limit))
        begin
            if (phase_reg == PH_BETWEEN)
            begin
                phase_next    = cfg.allow_empty ? PH_COLLECTING : PH_SKIPPING;
                kept_len_next = '0;
            end
            if (consumed_reg != CONSUMED_MAX)
            begin
                consumed_next = consumed_reg + 1'b1;
            end
            result_next.token_slot = token_count_reg[BYTE_W-1:0];
            if (phase_next == PH_SKIPPING && !item.is_delim)
            begin
                phase_next = PH_COLLECTING;
            end
            if (phase_next == PH_COLLECTING)
            begin
                if (item.is_delim)
                begin
                    result_next.token_closed = 1'b1;
                    token_count_next         = token_count_reg + 1'b1;
                    phase_next               = PH_BETWEEN;
                    kept_len_next            = '0;
                end
                else if (kept_len_next < cfg.max_token_len)
                begin
                    result_next.byte_kept = 1'b1;
                    kept_len_next         = kept_len_next + 1'b1;
                end
            end
            result_next.token_total  = token_count_next;
            result_next.consumed_len = consumed_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_BETWEEN;
            token_count_reg <= '0;
            kept_len_reg    <= '0;
            consumed_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg       <= phase_next;
                token_count_reg <= token_count_next;
                kept_len_reg    <= kept_len_next;
                consumed_reg    <= consumed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[hw/rtl/delimiter_set_tokenizer.sv]
// Top level of the delimiter set tokenizer: configuration registers and stream ports.
`timescale 1ns / 1ps

// The tokenizer takes one string byte per word and returns exactly one result word per byte,
// sustaining one byte per clock cycle while the output is not stalled; each byte passes through
// the front-end item register, a queue entry and the back-end result register. The rate is set
// by the back-end state update, which handles one byte per cycle, while a four-entry queue lets
// the input side keep accepting during short output stalls. The user must write registers
// through the configuration channel only while no byte is in flight; the block does not
// enforce this. A zero byte ends the string, reports the totals and clears the string state.

module delimiter_set_tokenizer
    import dst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // byte_value [7:0]
    input  logic [BYTE_W-1:0]      s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // token_byte [7:0], token_slot [15:8], token_total [24:16], consumed_len [40:25], zeros above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // byte_kept [0], token_closed [1]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    // string_done
    output logic                   m_axis_tlast
);

    logic [CFG_DATA_W-1:0] delim_mask_reg [4];
    logic                  allow_empty_reg;
    logic [LEN_W-1:0]      max_token_len_reg;
    logic [COUNT_W-1:0]    max_tokens_reg;
    logic [MASK_W-1:0]     delim_mask;
    dst_cfg_t              cfg;
    logic                  cfg_write;

    logic        push_valid;
    dst_item_t   push_item;
    logic        queue_full;
    logic        pop_valid;
    logic        pop_ready;
    dst_item_t   pop_item;
    dst_result_t result;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_mask_reg[0] <= '0;
            delim_mask_reg[1] <= '0;
            delim_mask_reg[2] <= '0;
            delim_mask_reg[3] <= '0;
            allow_empty_reg   <= 1'b0;
            max_token_len_reg <= MAX_TOKEN_LEN;
            max_tokens_reg    <= MAX_TOKENS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DELIM_0:       delim_mask_reg[0] <= cfg_data;
                CFG_DELIM_1:       delim_mask_reg[1] <= cfg_data;
                CFG_DELIM_2:       delim_mask_reg[2] <= cfg_data;
                CFG_DELIM_3:       delim_mask_reg[3] <= cfg_data;
                CFG_ALLOW_EMPTY:   allow_empty_reg   <= cfg_data[0];
                CFG_MAX_TOKEN_LEN: max_token_len_reg <= cfg_data[LEN_W-1:0];
                CFG_MAX_TOKENS:    max_tokens_reg    <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign delim_mask = {delim_mask_reg[3], delim_mask_reg[2],
                         delim_mask_reg[1], delim_mask_reg[0]};

    assign cfg.allow_empty   = allow_empty_reg;
    assign cfg.max_token_len = max_token_len_reg;
    assign cfg.max_tokens    = max_tokens_reg;

    dst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .delim_mask (delim_mask),
        .push_valid (push_valid),
        .queue_full (queue_full),
        .push_item  (push_item)
    );

    dst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {7'd0, result.consumed_len, result.token_total,
                           result.token_slot, result.token_byte};
    assign m_axis_tuser = {result.token_closed, result.byte_kept};
    assign m_axis_tlast = result.string_done;

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'd0 && !m_axis_tuser[0])
        else $error("terminator word carries a kept byte");

    a_kept_or_closed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("one word both kept a byte and closed a token");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[24:16] <= MAX_TOKENS)
        else $error("token total beyond the token limit");

    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("queued byte not taken by an idle back end");

endmodule

[tb/tb.sv]
// Self-checking testbench for the delimiter set tokenizer: directed table, random strings, long string.
`timescale 1ns / 1ps

module tb;
    import dst_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int SHOWN_LIMIT   = 10;
    localparam int PHASE_BYTES   = 150;
    localparam int RANDOM_PHASES = 8;
    localparam int LONG_STRING   = 100;
    localparam int LONG_TOKEN    = 40;
    localparam int HOLD_CYCLES   = 300;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int MASK_NONE   = 0;
    localparam int MASK_ALL    = 1;
    localparam int MASK_DENSE  = 2;
    localparam int MASK_SPARSE = 3;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] reg_code;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [BYTE_W-1:0]      value;
        bit                     typed;
        dst_result_t            result;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    logic [MASK_W-1:0]  delim_set;
    logic               allow_empty_cfg;
    logic [LEN_W-1:0]   max_len_cfg;
    logic [COUNT_W-1:0] max_tok_cfg;

    logic [1:0] tok_phase;
    int         tok_count;
    int         kept_len;
    int         consumed;

    dst_result_t expected_q[$];
    stim_row_t   stim_rows[$];
    int          fail_count;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_left;
    int          sent_in_phase;

    delimiter_set_tokenizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic dst_result_t tokenize_byte(input logic [BYTE_W-1:0] value);
        dst_result_t res;
        int          tok_limit;
        int          len_limit;
        logic        delim;
        res            = '0;
        res.token_byte = value;
        delim          = delim_set[value];
        tok_limit      = (max_tok_cfg > MAX_TOKENS) ? int'(MAX_TOKENS) : int'(max_tok_cfg);
        len_limit      = (max_len_cfg > MAX_TOKEN_LEN) ? int'(MAX_TOKEN_LEN) : int'(max_len_cfg);
        if (value == '0)
        begin
            res.string_done = 1'b1;
            if (tok_phase != PH_BETWEEN)
            begin
                res.token_slot   = tok_count[BYTE_W-1:0];
                res.token_closed = 1'b1;
                tok_count++;
            end
            res.token_total  = tok_count[COUNT_W-1:0];
            res.consumed_len = consumed[CONSUMED_W-1:0];
            tok_phase        = PH_BETWEEN;
            tok_count        = 0;
            kept_len         = 0;
            consumed         = 0;
            return res;
        end
        if (tok_phase == PH_BETWEEN)
        begin
            if (tok_count >= tok_limit)
            begin
                res.token_total  = tok_count[COUNT_W-1:0];
                res.consumed_len = consumed[CONSUMED_W-1:0];
                return res;
            end
            tok_phase = allow_empty_cfg ? PH_COLLECTING : PH_SKIPPING;
            kept_len  = 0;
        end
        if (consumed < int'(CONSUMED_MAX))
            consumed++;
        res.token_slot = tok_count[BYTE_W-1:0];
        if (tok_phase == PH_SKIPPING && !delim)
            tok_phase = PH_COLLECTING;
        if (tok_phase == PH_COLLECTING)
        begin
            if (delim)
            begin
                res.token_closed = 1'b1;
                tok_count++;
                tok_phase = PH_BETWEEN;
                kept_len  = 0;
            end
            else if (kept_len < len_limit)
            begin
                res.byte_kept = 1'b1;
                kept_len++;
            end
        end
        res.token_total  = tok_count[COUNT_W-1:0];
        res.consumed_len = consumed[CONSUMED_W-1:0];
        return res;
    endfunction

    function automatic dst_result_t mk_res(input logic [BYTE_W-1:0] value, input bit kept,
                                           input logic [BYTE_W-1:0] slot, input bit closed,
                                           input bit done, input int total, input int used);
        dst_result_t res;
        res.token_byte   = value;
        res.byte_kept    = kept;
        res.token_slot   = slot;
        res.token_closed = closed;
        res.string_done  = done;
        res.token_total  = total[COUNT_W-1:0];
        res.consumed_len = used[CONSUMED_W-1:0];
        return res;
    endfunction

    function automatic string fmt_result(input dst_result_t r);
        return $sformatf("byte=%02h kept=%0d slot=%0d closed=%0d done=%0d total=%0d consumed=%0d",
                         r.token_byte, r.byte_kept, r.token_slot, r.token_closed,
                         r.string_done, r.token_total, r.consumed_len);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_LIMIT)
            $display("%s", msg);
    endfunction

    function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] code,
                                    input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.is_cfg    = 1'b1;
        row.reg_code  = code;
        row.reg_value = data;
        row.value     = '0;
        row.typed     = 1'b0;
        row.result    = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_byte(input logic [BYTE_W-1:0] value);
        stim_row_t row;
        row.is_cfg    = 1'b0;
        row.reg_code  = '0;
        row.reg_value = '0;
        row.value     = value;
        row.typed     = 1'b0;
        row.result    = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_known(input logic [BYTE_W-1:0] value, input dst_result_t res);
        stim_row_t row;
        row.is_cfg    = 1'b0;
        row.reg_code  = '0;
        row.reg_value = '0;
        row.value     = value;
        row.typed     = 1'b1;
        row.result    = res;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte(input bit want_delim);
        logic [BYTE_W-1:0] v;
        v = 8'h01;
        for (int tries = 0; tries < 64; tries++)
        begin
            v = BYTE_W'($urandom_range(1, 255));
            if (delim_set[v] == want_delim)
                return v;
        end
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_mask(input int kind);
        case (kind)
            MASK_NONE:  return '0;
            MASK_ALL:   return '1;
            MASK_DENSE: return {$urandom, $urandom};
            default:    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
    endfunction

    function automatic void set_idling(input int mode);
        case (mode)
            IDLE_SENDER:
            begin
                src_idle_pct = 51;
                snk_idle_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                src_idle_pct = 0;
                snk_idle_pct = 51;
            end
            IDLE_BOTH:
            begin
                src_idle_pct = 37;
                snk_idle_pct = 37;
            end
            default:
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value, input bit typed,
                             input dst_result_t known);
        int          gap;
        dst_result_t res;
        gap = 0;
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = tokenize_byte(value);
        expected_q.push_back(typed ? known : res);
        sent_in_phase++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] code,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= code;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (code)
            CFG_DELIM_0:       delim_set[63:0]    = data;
            CFG_DELIM_1:       delim_set[127:64]  = data;
            CFG_DELIM_2:       delim_set[191:128] = data;
            CFG_DELIM_3:       delim_set[255:192] = data;
            CFG_ALLOW_EMPTY:   allow_empty_cfg    = data[0];
            CFG_MAX_TOKEN_LEN: max_len_cfg        = data[LEN_W-1:0];
            CFG_MAX_TOKENS:    max_tok_cfg        = data[COUNT_W-1:0];
            default:           ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] m0, input logic [CFG_DATA_W-1:0] m1,
                                input logic [CFG_DATA_W-1:0] m2, input logic [CFG_DATA_W-1:0] m3,
                                input logic [CFG_DATA_W-1:0] allow,
                                input logic [CFG_DATA_W-1:0] len,
                                input logic [CFG_DATA_W-1:0] toks);
        wait_idle();
        cfg_write(CFG_DELIM_0, m0);
        cfg_write(CFG_DELIM_1, m1);
        cfg_write(CFG_DELIM_2, m2);
        cfg_write(CFG_DELIM_3, m3);
        cfg_write(CFG_ALLOW_EMPTY, allow);
        cfg_write(CFG_MAX_TOKEN_LEN, len);
        cfg_write(CFG_MAX_TOKENS, toks);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] pad;
        logic [CFG_DATA_W-1:0] len_val;
        logic [CFG_DATA_W-1:0] tok_val;
        int                    kind;
        kind = $urandom_range(0, 5);
        if (kind > MASK_SPARSE)
            kind = MASK_SPARSE;
        pad = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
        case ($urandom_range(0, 5))
            0:       len_val = '0;
            1:       len_val = CFG_DATA_W'(1);
            2:       len_val = CFG_DATA_W'(MAX_TOKEN_LEN);
            5:       len_val = CFG_DATA_W'($urandom_range(0, 2047));
            default: len_val = CFG_DATA_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 7))
            0:       tok_val = '0;
            1:       tok_val = CFG_DATA_W'(1);
            2:       tok_val = CFG_DATA_W'(MAX_TOKENS);
            3:       tok_val = CFG_DATA_W'(511);
            4:       tok_val = CFG_DATA_W'($urandom_range(0, 511));
            default: tok_val = CFG_DATA_W'($urandom_range(1, 6));
        endcase
        write_config(random_mask(kind), random_mask(kind), random_mask(kind), random_mask(kind),
                     (pad << 1) | CFG_DATA_W'($urandom_range(0, 1)),
                     (pad << LEN_W) | len_val, (pad << COUNT_W) | tok_val);
    endtask

    task automatic send_well_formed();
        int n_tok;
        int n_len;
        int n_sep;
        n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
        repeat ($urandom_range(0, 2)) send_byte(pick_byte(1'b1), 1'b0, '0);
        for (int t = 0; t < n_tok; t++)
        begin
            n_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            repeat (n_len) send_byte(pick_byte(1'b0), 1'b0, '0);
            n_sep = (t == n_tok - 1) ? $urandom_range(0, 2) : $urandom_range(1, 3);
            repeat (n_sep) send_byte(pick_byte(1'b1), 1'b0, '0);
        end
        send_byte(8'h00, 1'b0, '0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 30))
        begin
            if ($urandom_range(0, 19) == 0)
                send_byte(8'h00, 1'b0, '0);
            else
                send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        dst_result_t want;
        dst_result_t got;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.token_byte   = m_axis_tdata[7:0];
                got.token_slot   = m_axis_tdata[15:8];
                got.token_total  = m_axis_tdata[24:16];
                got.consumed_len = m_axis_tdata[40:25];
                got.byte_kept    = m_axis_tuser[0];
                got.token_closed = m_axis_tuser[1];
                got.string_done  = m_axis_tlast;
                if (expected_q.size() == 0)
                    note_failure({"Unexpected result word: ", fmt_result(got)});
                else
                begin
                    want = expected_q.pop_front();
                    if (got.token_byte != want.token_byte || got.byte_kept != want.byte_kept
                        || got.token_slot != want.token_slot
                        || got.token_closed != want.token_closed
                        || got.string_done != want.string_done
                        || got.token_total != want.token_total
                        || got.consumed_len != want.consumed_len)
                        note_failure({"Mismatch: expected ", fmt_result(want),
                                      " actual ", fmt_result(got)});
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        delim_set       = '0;
        allow_empty_cfg = 1'b0;
        max_len_cfg     = MAX_TOKEN_LEN;
        max_tok_cfg     = MAX_TOKENS;
        tok_phase       = PH_BETWEEN;
        tok_count       = 0;
        kept_len        = 0;
        consumed        = 0;
        fail_count      = 0;
        hold_left       = 0;
        sent_in_phase   = 0;
        set_idling(IDLE_NONE);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: no delimiters, so every nonzero byte is kept.
        add_known(8'h00, mk_res(8'h00, 0, 0, 0, 1, 0, 0));
        add_known(8'hFF, mk_res(8'hFF, 1, 0, 0, 0, 0, 1));
        add_byte(8'h80);
        add_known(8'h00, mk_res(8'h00, 0, 0, 1, 1, 1, 2));
        // Space, comma, '@', 0x80, 0xFF and the zero byte itself marked as delimiters.
        add_cfg(CFG_DELIM_0, 64'h0000_1001_0000_0001);
        add_cfg(CFG_DELIM_1, 64'h0000_0000_0000_0001);
        add_cfg(CFG_DELIM_2, 64'h0000_0000_0000_0001);
        add_cfg(CFG_DELIM_3, 64'h8000_0000_0000_0000);
        add_cfg(CFG_ALLOW_EMPTY, 64'd0);
        add_cfg(CFG_MAX_TOKEN_LEN, 64'd2);
        add_cfg(CFG_MAX_TOKENS, 64'd2);
        add_byte(8'h20);
        add_byte(8'h41);
        add_byte(8'h42);
        add_byte(8'h43);
        add_byte(8'h2C);
        add_byte(8'hFF);
        add_byte(8'h44);
        add_byte(8'h40);
        add_known(8'h45, mk_res(8'h45, 0, 0, 0, 0, 2, 8));
        add_known(8'h00, mk_res(8'h00, 0, 0, 0, 1, 2, 8));
        // With no tokens allowed every nonzero byte is ignored.
        add_cfg(CFG_ALLOW_EMPTY, 64'd1);
        add_cfg(CFG_MAX_TOKEN_LEN, 64'd0);
        add_cfg(CFG_MAX_TOKENS, 64'd0);
        add_known(8'h41, mk_res(8'h41, 0, 0, 0, 0, 0, 0));
        add_known(8'h00, mk_res(8'h00, 0, 0, 0, 1, 0, 0));
        add_cfg(CFG_MAX_TOKENS, 64'd511);
        add_cfg(CFG_MAX_TOKEN_LEN, 64'(MAX_TOKEN_LEN));
        add_byte(8'h2C);
        add_byte(8'h80);
        add_byte(8'h7F);
        add_byte(8'h00);
        // The terminator also closes a token that is still skipping delimiters.
        add_cfg(CFG_ALLOW_EMPTY, 64'd0);
        add_cfg(CFG_MAX_TOKEN_LEN, 64'd0);
        add_byte(8'h31);
        add_byte(8'h20);
        add_byte(8'h20);
        add_byte(8'h00);

        set_idling(IDLE_BOTH);
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
            begin
                wait_idle();
                cfg_write(stim_rows[i].reg_code, stim_rows[i].reg_value);
            end
            else
                send_byte(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].result);
        end

        // Every byte a delimiter with empty tokens kept, so the token limit is reached.
        write_config('1, '1, '1, '1, 64'd1, 64'(MAX_TOKEN_LEN), 64'd511);
        set_idling(IDLE_RECEIVER);
        repeat (300) send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0, '0);
        send_byte(8'h00, 1'b0, '0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_config();
            set_idling(ph % 4);
            if (ph == 4)
                hold_left = HOLD_CYCLES;
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_BYTES)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_noise();
                else
                    send_well_formed();
            end
        end

        // One long string whose tokens run well past the byte limit.
        write_config('0, '0, '0, 64'h8000_0000_0000_0000, 64'd0, 64'd16,
                     64'(MAX_TOKENS));
        set_idling(IDLE_NONE);
        for (int n = 0; n < LONG_STRING; n++)
        begin
            if (n % LONG_TOKEN == LONG_TOKEN - 1)
                send_byte(8'hFF, 1'b0, '0);
            else
                send_byte(BYTE_W'($urandom_range(1, 254)), 1'b0, '0);
        end
        send_byte(8'h00, 1'b0, '0);

        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[delimiter_set_tokenizer.f]
hw/rtl/dst_pkg.sv
hw/rtl/dst_front.sv
hw/rtl/dst_queue.sv
hw/rtl/dst_back.sv
hw/rtl/delimiter_set_tokenizer.sv
tb/tb.sv
